// ----- hw/rtl/jsu_pkg.sv -----
// Shared types and constants for the JSON string unescape / UTF-8 decode unit.
// No dependencies; imported by the channel interfaces and all modules.

package jsu_pkg;

   localparam int ByteW   = 8;
   localparam int CpW     = 21;
   localparam int StatusW = 4;

   // decoder modes
   localparam logic [1:0] MODE_TEXT = 2'd0;
   localparam logic [1:0] MODE_ESC  = 2'd1;
   localparam logic [1:0] MODE_HEX  = 2'd2;
   localparam logic [1:0] MODE_UTF  = 2'd3;

   // result status codes
   localparam logic [StatusW-1:0] ST_CHAR        = 4'd0;
   localparam logic [StatusW-1:0] ST_CLOSED      = 4'd1;
   localparam logic [StatusW-1:0] ST_NUL         = 4'd2;
   localparam logic [StatusW-1:0] ST_BAD_LEAD    = 4'd3;
   localparam logic [StatusW-1:0] ST_BAD_CONT    = 4'd4;
   localparam logic [StatusW-1:0] ST_OVERLONG3   = 4'd5;
   localparam logic [StatusW-1:0] ST_OVERLONG4   = 4'd6;
   localparam logic [StatusW-1:0] ST_ESC_NUL     = 4'd7;
   localparam logic [StatusW-1:0] ST_BAD_ESC     = 4'd8;
   localparam logic [StatusW-1:0] ST_HEX_NUL     = 4'd9;
   localparam logic [StatusW-1:0] ST_BAD_HEX     = 4'd10;
   localparam logic [StatusW-1:0] ST_UNPAIRED_HI = 4'd11;

   // characters of interest
   localparam logic [ByteW-1:0] CH_NUL       = 8'h00;
   localparam logic [ByteW-1:0] CH_QUOTE     = 8'h22;
   localparam logic [ByteW-1:0] CH_BACKSLASH = 8'h5C;
   localparam logic [ByteW-1:0] CH_SLASH     = 8'h2F;
   localparam logic [ByteW-1:0] CH_LOWER_B   = 8'h62;
   localparam logic [ByteW-1:0] CH_LOWER_F   = 8'h66;
   localparam logic [ByteW-1:0] CH_LOWER_N   = 8'h6E;
   localparam logic [ByteW-1:0] CH_LOWER_R   = 8'h72;
   localparam logic [ByteW-1:0] CH_LOWER_T   = 8'h74;
   localparam logic [ByteW-1:0] CH_LOWER_U   = 8'h75;
   localparam logic [ByteW-1:0] CH_BS        = 8'h08;
   localparam logic [ByteW-1:0] CH_FF        = 8'h0C;
   localparam logic [ByteW-1:0] CH_LF        = 8'h0A;
   localparam logic [ByteW-1:0] CH_CR        = 8'h0D;
   localparam logic [ByteW-1:0] CH_TAB       = 8'h09;

   // surrogate prefixes (top six bits of a 16-bit unit)
   localparam logic [5:0] SURR_HIGH = 6'b110110;
   localparam logic [5:0] SURR_LOW  = 6'b110111;

   localparam logic [CpW-1:0] MIN_CP3  = 21'h000800;
   localparam logic [CpW-1:0] MIN_CP4  = 21'h010000;
   localparam logic [CpW-1:0] SUPP_BASE = 21'h010000;

   typedef struct packed {
      logic [1:0]     mode;
      logic [1:0]     utf_remaining;
      logic [2:0]     utf_length;
      logic [CpW-1:0] accum;
      logic [1:0]     hex_count;
      logic [15:0]    high_half;
      logic           pair_pending;
   } dec_state_type;

   typedef struct packed {
      logic               valid;
      logic [CpW-1:0]     code_point;
      logic [StatusW-1:0] status;
   } dec_result_type;

endpackage

// ----- hw/rtl/jsu_req_if.sv -----
// Input byte channel: valid/ready handshake carrying one raw string byte.
// Depends on jsu_pkg.

interface jsu_req_if
   import jsu_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

// ----- hw/rtl/jsu_rsp_if.sv -----
// Result channel: valid/ready handshake carrying one decoded code point or status.
// Depends on jsu_pkg.

interface jsu_rsp_if
   import jsu_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [CpW-1:0]     code_point;
   logic [StatusW-1:0] status;
   logic               last;

   modport source (output valid, output code_point, output status, output last, input ready);
   modport sink   (input valid, input code_point, input status, input last, output ready);
endinterface

// ----- hw/rtl/jsu_step.sv -----
// One-byte decode step: next decoder state and optional result from current state.
// Purely combinational; depends on jsu_pkg.

module jsu_step
   import jsu_pkg::*;
(
   input  dec_state_type    cur,
   input  logic [ByteW-1:0] byte_in,
   output dec_state_type    nxt,
   output dec_result_type   res
);

   logic        hex_ok;
   logic [3:0]  hex_digit;
   logic [15:0] hex_acc;
   logic [CpW-1:0] utf_acc;

   always_comb begin
      hex_ok    = 1'b1;
      hex_digit = 4'd0;
      if (byte_in inside {[8'h30:8'h39]}) begin
         hex_digit = byte_in[3:0];
      end else if (byte_in inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
         hex_digit = byte_in[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign hex_acc = {cur.accum[11:0], hex_digit};
   assign utf_acc = {cur.accum[CpW-7:0], byte_in[5:0]};

   always_comb begin
      nxt            = cur;
      res.valid      = 1'b0;
      res.code_point = '0;
      res.status     = ST_CHAR;

      case (cur.mode)
         MODE_ESC: begin
            nxt.mode  = MODE_TEXT;
            res.valid = 1'b1;
            case (byte_in)
               CH_BACKSLASH: res.code_point = CpW'(CH_BACKSLASH);
               CH_QUOTE:     res.code_point = CpW'(CH_QUOTE);
               CH_SLASH:     res.code_point = CpW'(CH_SLASH);
               CH_LOWER_B:   res.code_point = CpW'(CH_BS);
               CH_LOWER_F:   res.code_point = CpW'(CH_FF);
               CH_LOWER_N:   res.code_point = CpW'(CH_LF);
               CH_LOWER_R:   res.code_point = CpW'(CH_CR);
               CH_LOWER_T:   res.code_point = CpW'(CH_TAB);
               CH_LOWER_U: begin
                  res.valid     = 1'b0;
                  nxt.mode      = MODE_HEX;
                  nxt.hex_count = 2'd0;
                  nxt.accum     = '0;
               end
               CH_NUL: begin
                  nxt        = '0;
                  res.status = ST_ESC_NUL;
               end
               default: begin
                  nxt        = '0;
                  res.status = ST_BAD_ESC;
               end
            endcase
         end

         MODE_HEX: begin
            if (!hex_ok) begin
               nxt        = '0;
               res.valid  = 1'b1;
               res.status = (byte_in == CH_NUL) ? ST_HEX_NUL : ST_BAD_HEX;
            end else if (cur.hex_count != 2'd3) begin
               nxt.accum     = CpW'(hex_acc);
               nxt.hex_count = cur.hex_count + 2'd1;
            end else begin
               nxt.mode      = MODE_TEXT;
               nxt.hex_count = 2'd0;
               nxt.accum     = '0;
               if (!cur.pair_pending) begin
                  if (hex_acc[15:10] == SURR_HIGH) begin
                     nxt.high_half    = hex_acc;
                     nxt.pair_pending = 1'b1;
                  end else begin
                     res.valid      = 1'b1;
                     res.code_point = CpW'(hex_acc);
                  end
               end else if (hex_acc[15:10] != SURR_LOW) begin
                  nxt        = '0;
                  res.valid  = 1'b1;
                  res.status = ST_UNPAIRED_HI;
               end else begin
                  nxt.pair_pending = 1'b0;
                  res.valid        = 1'b1;
                  res.code_point   = SUPP_BASE
                                     + CpW'({cur.high_half[9:0], hex_acc[9:0]});
               end
            end
         end

         MODE_UTF: begin
            if (!byte_in[7]) begin
               nxt        = '0;
               res.valid  = 1'b1;
               res.status = ST_BAD_CONT;
            end else if (cur.utf_remaining > 2'd1) begin
               nxt.accum         = utf_acc;
               nxt.utf_remaining = cur.utf_remaining - 2'd1;
            end else if (cur.utf_length == 3'd3 && utf_acc < MIN_CP3) begin
               nxt        = '0;
               res.valid  = 1'b1;
               res.status = ST_OVERLONG3;
            end else if (cur.utf_length == 3'd4 && utf_acc < MIN_CP4) begin
               nxt        = '0;
               res.valid  = 1'b1;
               res.status = ST_OVERLONG4;
            end else begin
               nxt.mode          = MODE_TEXT;
               nxt.utf_remaining = 2'd0;
               nxt.utf_length    = 3'd0;
               nxt.accum         = '0;
               res.valid         = 1'b1;
               res.code_point    = utf_acc;
            end
         end

         default: begin
            nxt.mode = MODE_TEXT;
            if (byte_in == CH_NUL) begin
               nxt        = '0;
               res.valid  = 1'b1;
               res.status = ST_NUL;
            end else if (byte_in == CH_QUOTE) begin
               nxt        = '0;
               res.valid  = 1'b1;
               res.status = ST_CLOSED;
            end else if (byte_in == CH_BACKSLASH) begin
               nxt.mode = MODE_ESC;
            end else if (!byte_in[7]) begin
               res.valid      = 1'b1;
               res.code_point = CpW'(byte_in);
            end else if (byte_in inside {[8'hC0:8'hDF]}) begin
               nxt.mode          = MODE_UTF;
               nxt.accum         = CpW'(byte_in[4:0]);
               nxt.utf_remaining = 2'd1;
               nxt.utf_length    = 3'd2;
            end else if (byte_in inside {[8'hE0:8'hEF]}) begin
               nxt.mode          = MODE_UTF;
               nxt.accum         = CpW'(byte_in[3:0]);
               nxt.utf_remaining = 2'd2;
               nxt.utf_length    = 3'd3;
            end else if (byte_in inside {[8'hF0:8'hF7]}) begin
               nxt.mode          = MODE_UTF;
               nxt.accum         = CpW'(byte_in[2:0]);
               nxt.utf_remaining = 2'd3;
               nxt.utf_length    = 3'd4;
            end else begin
               // stray continuation byte or F8..FF
               nxt        = '0;
               res.valid  = 1'b1;
               res.status = ST_BAD_LEAD;
            end
         end
      endcase
   end

endmodule

// ----- hw/rtl/json_string_unescape_utf8_unit.sv -----
// JSON string body decoder: backslash unescape, \uXXXX with surrogate pairing,
// UTF-8 decode. Byte input register, decode step, result register.
// Usage:
//   req_bus carries one byte of a string body per beat, starting after the
//   opening quote. rsp_bus returns at most one beat per byte: a code point
//   with status 0, or a terminal status (closing quote or an error code)
//   with last high and code_point zero. After a terminal beat the decoder is
//   back in plain text mode, ready for the next string.
//   Bytes that only advance the decoder (backslash, hex digits, UTF-8 lead
//   and inner continuation bytes, a held high surrogate) produce no beat.
//   Path: a byte is held in the input register, and its result is written to
//   the result register, which drives rsp_bus.
//   Throughput: one byte per cycle when rsp_bus does not stall; the whole
//   decode of a byte is one combinational step between the input and result registers.
//   Stall: while rsp_bus.ready is low and a result waits, the byte already in
//   the input register holds and req_bus.ready drops; a byte that produces no
//   result still needs the result register free to advance.
//   Reset (synchronous, active high) empties both registers and returns the
//   decoder to plain text mode with no surrogate pending.

module json_string_unescape_utf8_unit
   import jsu_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_bus,
   jsu_rsp_if.source rsp_bus
);

   logic             in_valid_ff, in_valid_in;
   logic [ByteW-1:0] in_byte_ff;

   dec_state_type    state_ff, state_in;
   dec_result_type   step_res;

   logic               out_valid_ff, out_valid_in;
   logic [CpW-1:0]     out_cp_ff;
   logic [StatusW-1:0] out_status_ff;

   logic advance;
   logic req_take;

   jsu_step u_step (
      .cur     (state_ff),
      .byte_in (in_byte_ff),
      .nxt     (state_in),
      .res     (step_res)
   );

   assign advance      = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !in_valid_ff || advance;
   assign req_take     = req_bus.valid && req_bus.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = in_valid_ff && step_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (in_valid_ff && advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_bus.byte_in;
      end
      if (advance && in_valid_ff && step_res.valid) begin
         out_cp_ff     <= step_res.code_point;
         out_status_ff <= step_res.status;
      end
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.code_point = out_cp_ff;
   assign rsp_bus.status     = out_status_ff;
   assign rsp_bus.last       = (out_status_ff != ST_CHAR);

endmodule
